// ===== hdl/fltm_pkg.sv =====
// ----------------------------------------------------------------------------
// fltm_pkg
// Shared types and codes for the four-level page table manager.
// ----------------------------------------------------------------------------
package fltm_pkg;

	localparam int IDX_W   = 9;
	localparam int ENTRIES = 512;

	localparam logic [2:0] OP_MAP   = 3'd0;
	localparam logic [2:0] OP_UNMAP = 3'd1;
	localparam logic [2:0] OP_QUERY = 3'd2;
	localparam logic [2:0] OP_SPLIT = 3'd3;
	localparam logic [2:0] OP_RAW   = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ABSENT  = 3'd1;
	localparam logic [2:0] ST_ALIGN   = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_OUTSIDE = 3'd4;

	localparam logic [1:0] LVL_PML4 = 2'd0;
	localparam logic [1:0] LVL_PDPT = 2'd1;
	localparam logic [1:0] LVL_PD   = 2'd2;
	localparam logic [1:0] LVL_PT   = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_ZERO,
		S_LINK,
		S_SFILL,
		S_SLINK,
		S_LEAF,
		S_UNMAP,
		S_RAW,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [51:0] translated_address;
		logic        invalidate;
		logic [47:0] invalidate_address;
		logic        invalidate_window;
	} rsp_t;

endpackage

// ===== hdl/fltm_chan_if.sv =====
// ----------------------------------------------------------------------------
// fltm_chan_if
// Request and response channels of the page table manager.
// ----------------------------------------------------------------------------
interface fltm_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [47:0] virtual_address;
	logic [51:0] physical_address;
	logic [1:0]  page_flags;
	logic [5:0]  raw_table_page;
	logic [8:0]  raw_entry_index;
	logic [63:0] raw_entry_value;

	modport source (output valid, opcode, virtual_address, physical_address, page_flags,
		raw_table_page, raw_entry_index, raw_entry_value, input ready);
	modport sink (input valid, opcode, virtual_address, physical_address, page_flags,
		raw_table_page, raw_entry_index, raw_entry_value, output ready);
endinterface

interface fltm_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [51:0] translated_address;
	logic        invalidate;
	logic [47:0] invalidate_address;
	logic        invalidate_window;

	modport source (output valid, status, translated_address, invalidate,
		invalidate_address, invalidate_window, input ready);
	modport sink (input valid, status, translated_address, invalidate,
		invalidate_address, invalidate_window, output ready);
endinterface

// ===== hdl/fltm_store.sv =====
// ----------------------------------------------------------------------------
// fltm_store
// Table store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fltm_store #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);

	logic [63:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/fltm_seq.sv =====
// ----------------------------------------------------------------------------
// fltm_seq
// Operation sequencer: walks the tables, allocates and fills pages.
// ----------------------------------------------------------------------------
module fltm_seq
	import fltm_pkg::*;
#(
	parameter int TABLE_PAGES = 64,
	parameter int PW          = 6,
	parameter int AW          = 15
) (
	input  logic           clk,
	input  logic           arst_n,
	fltm_req_if.sink       req,
	input  logic [39:0]    base_frame,
	output logic           res_valid,
	input  logic           res_ready,
	output rsp_t           res,
	output logic           mem_we,
	output logic [AW-1:0]  mem_waddr,
	output logic [63:0]    mem_wdata,
	output logic           mem_re,
	output logic [AW-1:0]  mem_raddr,
	input  logic [63:0]    mem_rdata
);

	localparam logic [PW:0]     TP_N      = (PW + 1)'(TABLE_PAGES);
	localparam logic [AW-1:0]   LAST_ADDR = AW'(TABLE_PAGES * ENTRIES - 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	state_t          state_q, state_d;
	logic [2:0]      op_q;
	logic [47:0]     va_q;
	logic [51:0]     pa_q;
	logic [1:0]      fl_q;
	logic [PW-1:0]   rpage_q;
	logic [8:0]      ridx_q;
	logic [63:0]     rval_q;
	logic            rbad_q;
	logic [1:0]      lvl_q, lvl_d;
	logic [PW-1:0]   cur_q, cur_d;
	logic [PW-1:0]   new_q, new_d;
	logic [PW:0]     nfp_q, nfp_d;
	logic [8:0]      cnt_q, cnt_d;
	logic [AW-1:0]   clr_q, clr_d;
	logic [63:0]     pde_q, pde_d;
	logic            split_q, split_d;
	rsp_t            rsp_q, rsp_d;

	logic [8:0]      idx;
	logic [39:0]     frame, diff, link_sum;
	logic            outside, present, huge, full, accept;
	logic [PW-1:0]   fpage;
	logic [31:0]     rp32;

	always_comb begin
		case (lvl_q)
			LVL_PML4: idx = va_q[47:39];
			LVL_PDPT: idx = va_q[38:30];
			LVL_PD:   idx = va_q[29:21];
			default:  idx = va_q[20:12];
		endcase
	end

	assign frame    = mem_rdata[51:12];
	assign diff     = frame - base_frame;
	assign outside  = (frame < base_frame) || (diff >= 40'(TABLE_PAGES));
	assign fpage    = diff[PW-1:0];
	assign present  = mem_rdata[0];
	assign huge     = mem_rdata[7];
	assign full     = nfp_q >= TP_N;
	assign link_sum = base_frame + 40'(new_q);
	assign accept   = req.valid && req.ready;
	assign rp32     = 32'(req.raw_table_page);

	always_comb begin
		state_d   = state_q;
		lvl_d     = lvl_q;
		cur_d     = cur_q;
		new_d     = new_q;
		nfp_d     = nfp_q;
		cnt_d     = cnt_q;
		clr_d     = clr_q;
		pde_d     = pde_q;
		split_d   = split_q;
		rsp_d     = rsp_q;
		req.ready = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = {cur_q, idx};
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = {cur_q, idx};

		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				clr_d     = clr_q + AW'(1);
				if (clr_q == LAST_ADDR) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					rsp_d   = '0;
					split_d = 1'b0;
					lvl_d   = LVL_PML4;
					cur_d   = '0;
					case (req.opcode)
						OP_MAP: begin
							if (req.virtual_address[11:0] != 12'h0 ||
									req.physical_address[11:0] != 12'h0) begin
								rsp_d.status = ST_ALIGN;
								state_d      = S_DONE;
							end else begin
								state_d = S_READ;
							end
						end
						OP_UNMAP, OP_QUERY, OP_SPLIT: state_d = S_READ;
						OP_RAW:  state_d = S_RAW;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_READ: begin
				mem_re  = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (op_q == OP_MAP) begin
					if (lvl_q == LVL_PD && present && huge) begin
						if (full) begin
							rsp_d.status = ST_FULL;
							state_d      = S_DONE;
						end else begin
							new_d   = nfp_q[PW-1:0];
							nfp_d   = nfp_q + 1'b1;
							pde_d   = mem_rdata;
							cnt_d   = '0;
							state_d = S_SFILL;
						end
					end else if (present) begin
						if (outside) begin
							rsp_d.status = ST_OUTSIDE;
							state_d      = S_DONE;
						end else begin
							cur_d   = fpage;
							lvl_d   = lvl_q + 2'd1;
							state_d = (lvl_q == LVL_PD) ? S_LEAF : S_READ;
						end
					end else if (full) begin
						rsp_d.status = ST_FULL;
						state_d      = S_DONE;
					end else begin
						new_d   = nfp_q[PW-1:0];
						nfp_d   = nfp_q + 1'b1;
						cnt_d   = '0;
						state_d = S_ZERO;
					end
				end else if (!present) begin
					rsp_d.status = ST_ABSENT;
					state_d      = S_DONE;
				end else if (lvl_q == LVL_PD && huge) begin
					if (op_q == OP_UNMAP) begin
						state_d = S_UNMAP;
					end else if (op_q == OP_QUERY) begin
						rsp_d.translated_address = {mem_rdata[51:21], va_q[20:0]};
						state_d = S_DONE;
					end else if (full) begin
						rsp_d.status = ST_FULL;
						state_d      = S_DONE;
					end else begin
						new_d   = nfp_q[PW-1:0];
						nfp_d   = nfp_q + 1'b1;
						pde_d   = mem_rdata;
						cnt_d   = '0;
						state_d = S_SFILL;
					end
				end else if (lvl_q == LVL_PDPT && huge && op_q == OP_QUERY) begin
					rsp_d.translated_address = {mem_rdata[51:30], va_q[29:0]};
					state_d = S_DONE;
				end else if (lvl_q == LVL_PT) begin
					if (op_q == OP_UNMAP) begin
						state_d = S_UNMAP;
					end else begin
						rsp_d.translated_address = {mem_rdata[51:12], va_q[11:0]};
						state_d = S_DONE;
					end
				end else if (lvl_q == LVL_PD && op_q == OP_SPLIT) begin
					// Already a table: nothing to split.
					state_d = S_DONE;
				end else if (outside) begin
					rsp_d.status = ST_OUTSIDE;
					state_d      = S_DONE;
				end else begin
					cur_d   = fpage;
					lvl_d   = lvl_q + 2'd1;
					state_d = S_READ;
				end
			end
			S_ZERO: begin
				mem_we    = 1'b1;
				mem_waddr = {new_q, cnt_q};
				cnt_d     = cnt_q + 9'd1;
				if (cnt_q == LAST_IDX) begin
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				// The link goes in after the zero fill, since the parent may sit in
				// the very page that was just handed out.
				mem_we    = 1'b1;
				mem_wdata = {12'h0, link_sum, 9'h0, fl_q[1], 2'b11};
				cur_d     = new_q;
				lvl_d     = lvl_q + 2'd1;
				state_d   = (lvl_q == LVL_PD) ? S_LEAF : S_READ;
			end
			S_SFILL: begin
				mem_we    = 1'b1;
				mem_waddr = {new_q, cnt_q};
				mem_wdata = {12'h0, pde_q[51:21], cnt_q, pde_q[11:8], 1'b0, pde_q[6:0]};
				cnt_d     = cnt_q + 9'd1;
				if (cnt_q == LAST_IDX) begin
					state_d = S_SLINK;
				end
			end
			S_SLINK: begin
				mem_we    = 1'b1;
				mem_wdata = {12'h0, link_sum, 9'h0, pde_q[2], 2'b11};
				if (op_q == OP_MAP) begin
					// Reread the directory entry and descend through the new table.
					split_d = 1'b1;
					state_d = S_READ;
				end else begin
					rsp_d.invalidate         = 1'b1;
					rsp_d.invalidate_address = {va_q[47:21], 21'h0};
					rsp_d.invalidate_window  = 1'b1;
					state_d                  = S_DONE;
				end
			end
			S_LEAF: begin
				mem_we    = 1'b1;
				mem_wdata = {12'h0, pa_q[51:12], 9'h0, fl_q[1], fl_q[0], 1'b1};
				rsp_d.invalidate         = 1'b1;
				rsp_d.invalidate_address = split_q ? {va_q[47:21], 21'h0} : va_q;
				rsp_d.invalidate_window  = split_q;
				state_d                  = S_DONE;
			end
			S_UNMAP: begin
				mem_we                   = 1'b1;
				rsp_d.invalidate         = 1'b1;
				rsp_d.invalidate_address = va_q;
				state_d                  = S_DONE;
			end
			S_RAW: begin
				mem_we       = !rbad_q;
				mem_waddr    = {rpage_q, ridx_q};
				mem_wdata    = rval_q;
				rsp_d.status = rbad_q ? ST_OUTSIDE : ST_OK;
				state_d      = S_DONE;
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign res = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			nfp_q   <= (PW + 1)'(1);
			split_q <= 1'b0;
			lvl_q   <= LVL_PML4;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			nfp_q   <= nfp_d;
			split_q <= split_d;
			lvl_q   <= lvl_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		new_q <= new_d;
		cnt_q <= cnt_d;
		pde_q <= pde_d;
		rsp_q <= rsp_d;
		if (accept) begin
			op_q    <= req.opcode;
			va_q    <= req.virtual_address;
			pa_q    <= req.physical_address;
			fl_q    <= req.page_flags;
			rpage_q <= rp32[PW-1:0];
			rbad_q  <= rp32 >= 32'(TABLE_PAGES);
			ridx_q  <= req.raw_entry_index;
			rval_q  <= req.raw_entry_value;
		end
	end

	a_nfp_range: assert property (@(posedge clk) disable iff (!arst_n)
		nfp_q != '0 && nfp_q <= TP_N)
		else $error("allocator pointer out of range");

	a_no_inv_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.invalidate |-> res.invalidate_address == '0 &&
			!res.invalidate_window)
		else $error("invalidate fields set without invalidate");

	a_fail_no_xlat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_OK |-> res.translated_address == '0)
		else $error("translation reported on a failed operation");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mem_we)
		else $error("store written while idle");

	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		nfp_q != $past(nfp_q) |-> $past(state_q) == S_EVAL)
		else $error("allocator moved outside evaluation");

endmodule

// ===== hdl/four_level_page_table_manager_unit.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_manager_unit
// Four-level page table store with map, unmap, query, split and raw write.
// ----------------------------------------------------------------------------
// After reset the block clears its table store one entry a cycle, all
// TABLE_PAGES * 512 entries (32768 at the default), before the first request
// word is taken; configuration writes are accepted meanwhile. All work goes
// through the one store memory with registered read data, so each table level
// visited passes through a read state and then an evaluate state. A map writes
// a zero fill for each table it creates, and a split of a 2 MiB entry writes a
// 512-entry fill. One operation runs at a time; a finished response word waits
// in an output register while the next request is taken.
module four_level_page_table_manager_unit
	import fltm_pkg::*;
#(
	parameter int TABLE_PAGES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	fltm_req_if.sink    req,
	fltm_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [39:0] cfg_wdata
);

	localparam int PW    = $clog2(TABLE_PAGES);
	localparam int AW    = PW + IDX_W;
	localparam int DEPTH = TABLE_PAGES * ENTRIES;

	logic [39:0]   base_q;
	logic          out_valid_q;
	rsp_t          out_q;
	logic          res_valid, res_ready;
	rsp_t          res;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [63:0]   mem_wdata, mem_rdata;

	fltm_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fltm_seq #(.TABLE_PAGES(TABLE_PAGES), .PW(PW), .AW(AW)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.base_frame (base_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (res_ready) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.status             = out_q.status;
	assign rsp.translated_address = out_q.translated_address;
	assign rsp.invalidate         = out_q.invalidate;
	assign rsp.invalidate_address = out_q.invalidate_address;
	assign rsp.invalidate_window  = out_q.invalidate_window;

endmodule
